### src/locd_pkg.sv
package locd_pkg;

    // datapath operations, one per cycle, issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_STK_RD,
        OP_ROW_RD,
        OP_IDX_INC,
        OP_SRCH_INIT,
        OP_SRCH_RD,
        OP_SRCH_OR,
        OP_DECIDE,
        OP_PUSH,
        OP_REL_RD,
        OP_SH_RD,
        OP_SH_WR,
        OP_POP,
        OP_MISS,
        OP_OUT
    } dp_op_t;

    // datapath status seen by the controller
    typedef struct packed {
        logic is_release;
        logic cls_ok;
        logic idx_lt_depth;
        logic idx_zero;
        logic edge_present;
        logic sweep_last;
        logic grew_any;
        logic stk_match;
        logic sh_more;
        logic out_free;
    } dp_status_t;

    localparam int unsigned CLASS_W = 5;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned TOTAL_W = 16;

endpackage

### src/locd_ctrl.sv
module locd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  locd_pkg::dp_status_t status,
    output locd_pkg::dp_op_t     op
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ACQ_TEST,
        S_ACQ_WSTK,
        S_ACQ_CHK,
        S_SRCH_RD,
        S_SRCH_OR,
        S_DECIDE,
        S_REL_TEST,
        S_REL_CMP,
        S_SH_TEST,
        S_SH_WR,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    // busy whenever an event is in progress
    assign in_stall = (state_reg != S_IDLE);

    // next state and datapath operation
    always_comb
    begin
        state_next = state_reg;
        op         = locd_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = locd_pkg::OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (status.is_release)
                    state_next = S_REL_TEST;
                else if (status.cls_ok)
                    state_next = S_ACQ_TEST;
                else
                    state_next = S_FIN;
            end
            S_ACQ_TEST:
            begin
                if (status.idx_lt_depth)
                begin
                    op         = locd_pkg::OP_STK_RD;
                    state_next = S_ACQ_WSTK;
                end
                else
                begin
                    op         = locd_pkg::OP_PUSH;
                    state_next = S_FIN;
                end
            end
            S_ACQ_WSTK:
            begin
                op         = locd_pkg::OP_ROW_RD;
                state_next = S_ACQ_CHK;
            end
            S_ACQ_CHK:
            begin
                if (status.edge_present)
                begin
                    op         = locd_pkg::OP_IDX_INC;
                    state_next = S_ACQ_TEST;
                end
                else
                begin
                    op         = locd_pkg::OP_SRCH_INIT;
                    state_next = S_SRCH_RD;
                end
            end
            S_SRCH_RD:
            begin
                op         = locd_pkg::OP_SRCH_RD;
                state_next = S_SRCH_OR;
            end
            S_SRCH_OR:
            begin
                op = locd_pkg::OP_SRCH_OR;
                if (status.sweep_last && !status.grew_any)
                    state_next = S_DECIDE;
                else
                    state_next = S_SRCH_RD;
            end
            S_DECIDE:
            begin
                op         = locd_pkg::OP_DECIDE;
                state_next = S_ACQ_TEST;
            end
            S_REL_TEST:
            begin
                if (status.idx_zero)
                begin
                    op         = locd_pkg::OP_MISS;
                    state_next = S_FIN;
                end
                else
                begin
                    op         = locd_pkg::OP_REL_RD;
                    state_next = S_REL_CMP;
                end
            end
            S_REL_CMP:
            begin
                if (status.stk_match)
                    state_next = S_SH_TEST;
                else
                    state_next = S_REL_TEST;
            end
            S_SH_TEST:
            begin
                if (status.sh_more)
                begin
                    op         = locd_pkg::OP_SH_RD;
                    state_next = S_SH_WR;
                end
                else
                begin
                    op         = locd_pkg::OP_POP;
                    state_next = S_FIN;
                end
            end
            S_SH_WR:
            begin
                op         = locd_pkg::OP_SH_WR;
                state_next = S_SH_TEST;
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    op         = locd_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### src/locd_dp.sv
module locd_dp #(
    parameter int unsigned NUM_CLASSES = 32,
    parameter int unsigned EDGE_LIMIT  = 256,
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  locd_pkg::dp_op_t                   op,
    output locd_pkg::dp_status_t               status,
    input  logic                               cmd,
    input  logic [locd_pkg::CLASS_W-1:0]       lock_class,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [locd_pkg::COUNT_W-1:0]       cycle_warnings,
    output logic [locd_pkg::COUNT_W-1:0]       edges_added,
    output logic [locd_pkg::COUNT_W-1:0]       held_count,
    output logic                               not_held,
    output logic [locd_pkg::TOTAL_W-1:0]       warnings_total
);

    localparam int unsigned CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned EW = $clog2(EDGE_LIMIT + 1);
    localparam logic [locd_pkg::COUNT_W-1:0] CNT_MAX = '1;
    localparam logic [locd_pkg::TOTAL_W-1:0] TOT_MAX = '1;
    localparam logic [locd_pkg::COUNT_W-1:0] CNT_ONE = {{(locd_pkg::COUNT_W-1){1'b0}}, 1'b1};
    localparam logic [locd_pkg::TOTAL_W-1:0] TOT_ONE = {{(locd_pkg::TOTAL_W-1){1'b0}}, 1'b1};

    // memories: order matrix rows and held stack
    logic [NUM_CLASSES-1:0]      mat_mem [NUM_CLASSES];
    logic [locd_pkg::CLASS_W-1:0] stk_mem [STACK_DEPTH];

    logic [NUM_CLASSES-1:0]      row_valid_reg;
    logic [NUM_CLASSES-1:0]      mat_q_reg;
    logic                        mat_v_reg;
    logic [locd_pkg::CLASS_W-1:0] stk_q_reg;

    logic                        cmd_reg;
    logic [locd_pkg::CLASS_W-1:0] cls_reg;
    logic [DW-1:0]               idx_reg;
    logic [DW-1:0]               depth_reg;
    logic [EW-1:0]               edge_total_reg;
    logic [locd_pkg::TOTAL_W-1:0] warn_total_reg;
    logic [locd_pkg::COUNT_W-1:0] warns_reg;
    logic [locd_pkg::COUNT_W-1:0] added_reg;
    logic                        missing_reg;
    logic [CW-1:0]               held_reg;
    logic [NUM_CLASSES-1:0]      row_reg;
    logic [NUM_CLASSES-1:0]      reach_reg;
    logic                        grew_reg;
    logic [CW-1:0]               sweep_reg;

    logic                        out_valid_reg;
    logic [locd_pkg::COUNT_W-1:0] out_warns_reg;
    logic [locd_pkg::COUNT_W-1:0] out_added_reg;
    logic [locd_pkg::COUNT_W-1:0] out_held_reg;
    logic                        out_miss_reg;
    logic [locd_pkg::TOTAL_W-1:0] out_total_reg;

    // derived values
    logic [6:0]             cls_wide;
    logic [6:0]             stk_wide;
    logic [6:0]             depth_wide;
    logic [CW-1:0]          cls_ix;
    logic [CW-1:0]          stk_ix;
    logic [NUM_CLASSES-1:0] cls_bit;
    logic [NUM_CLASSES-1:0] row_rd;
    logic [NUM_CLASSES-1:0] reach_new;
    logic                   grew_now;
    logic                   warn_hit;
    logic                   edge_ok;
    logic                   stk_room;
    logic                   out_free;
    logic [DW-1:0]          idx_dec;
    logic [DW:0]            idx_inc;
    logic [CW-1:0]          mat_raddr;
    logic [AW-1:0]          stk_raddr;

    assign cls_wide   = {2'b00, cls_reg};
    assign stk_wide   = {2'b00, stk_q_reg};
    assign depth_wide = 7'(depth_reg);
    assign cls_ix     = cls_wide[CW-1:0];
    assign stk_ix     = stk_wide[CW-1:0];
    assign cls_bit    = NUM_CLASSES'(1) << cls_ix;
    assign row_rd     = mat_v_reg ? mat_q_reg : '0;
    assign reach_new  = reach_reg | (reach_reg[sweep_reg] ? row_rd : '0);
    assign grew_now   = (reach_new != reach_reg);
    assign warn_hit   = reach_reg[held_reg];
    assign edge_ok    = (edge_total_reg < EW'(EDGE_LIMIT));
    assign stk_room   = (depth_reg < DW'(STACK_DEPTH));
    assign out_free   = !out_valid_reg || !out_stall;
    assign idx_dec    = idx_reg - DW'(1);
    assign idx_inc    = {1'b0, idx_reg} + (DW + 1)'(1);
    assign mat_raddr  = (op == locd_pkg::OP_ROW_RD) ? stk_ix : sweep_reg;

    // stack read address
    always_comb
    begin
        case (op)
            locd_pkg::OP_REL_RD: stk_raddr = idx_dec[AW-1:0];
            locd_pkg::OP_SH_RD:  stk_raddr = idx_inc[AW-1:0];
            default:             stk_raddr = idx_reg[AW-1:0];
        endcase
    end

    // status to the controller
    assign status.is_release   = cmd_reg;
    assign status.cls_ok       = (cls_wide < 7'(NUM_CLASSES));
    assign status.idx_lt_depth = (idx_reg < depth_reg);
    assign status.idx_zero     = (idx_reg == '0);
    assign status.edge_present = row_rd[cls_ix];
    assign status.sweep_last   = (sweep_reg == CW'(NUM_CLASSES - 1));
    assign status.grew_any     = grew_reg || grew_now;
    assign status.stk_match    = (stk_q_reg == cls_reg);
    assign status.sh_more      = (idx_inc < {1'b0, depth_reg});
    assign status.out_free     = out_free;

    // order matrix: one read port, one write port
    always_ff @(posedge clk)
    begin
        if (op == locd_pkg::OP_ROW_RD || op == locd_pkg::OP_SRCH_RD)
            mat_q_reg <= mat_mem[mat_raddr];
        if (op == locd_pkg::OP_DECIDE && !warn_hit && edge_ok)
            mat_mem[held_reg] <= row_reg | cls_bit;
    end

    // held stack: one read port, one write port
    always_ff @(posedge clk)
    begin
        if (op == locd_pkg::OP_STK_RD || op == locd_pkg::OP_REL_RD ||
            op == locd_pkg::OP_SH_RD)
            stk_q_reg <= stk_mem[stk_raddr];
        if (op == locd_pkg::OP_PUSH && stk_room)
            stk_mem[depth_reg[AW-1:0]] <= cls_reg;
        else if (op == locd_pkg::OP_SH_WR)
            stk_mem[idx_reg[AW-1:0]] <= stk_q_reg;
    end

    // counters, search state and result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg  <= '0;
            mat_v_reg      <= 1'b0;
            cmd_reg        <= 1'b0;
            cls_reg        <= '0;
            idx_reg        <= '0;
            depth_reg      <= '0;
            edge_total_reg <= '0;
            warn_total_reg <= '0;
            warns_reg      <= '0;
            added_reg      <= '0;
            missing_reg    <= 1'b0;
            held_reg       <= '0;
            row_reg        <= '0;
            reach_reg      <= '0;
            grew_reg       <= 1'b0;
            sweep_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_warns_reg  <= '0;
            out_added_reg  <= '0;
            out_held_reg   <= '0;
            out_miss_reg   <= 1'b0;
            out_total_reg  <= '0;
        end
        else
        begin
            if (op == locd_pkg::OP_ROW_RD || op == locd_pkg::OP_SRCH_RD)
                mat_v_reg <= row_valid_reg[mat_raddr];
            // result beat held until taken, new beat loaded on output
            if (op == locd_pkg::OP_OUT)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            case (op)
                locd_pkg::OP_LOAD:
                begin
                    cmd_reg     <= cmd;
                    cls_reg     <= lock_class;
                    warns_reg   <= '0;
                    added_reg   <= '0;
                    missing_reg <= 1'b0;
                    idx_reg     <= cmd ? depth_reg : '0;
                end
                locd_pkg::OP_ROW_RD:
                begin
                    held_reg <= stk_ix;
                end
                locd_pkg::OP_IDX_INC:
                begin
                    idx_reg <= idx_inc[DW-1:0];
                end
                locd_pkg::OP_SRCH_INIT:
                begin
                    row_reg   <= row_rd;
                    reach_reg <= cls_bit;
                    sweep_reg <= '0;
                    grew_reg  <= 1'b0;
                end
                locd_pkg::OP_SRCH_OR:
                begin
                    reach_reg <= reach_new;
                    if (status.sweep_last)
                    begin
                        sweep_reg <= '0;
                        grew_reg  <= 1'b0;
                    end
                    else
                    begin
                        sweep_reg <= sweep_reg + CW'(1);
                        grew_reg  <= grew_reg || grew_now;
                    end
                end
                locd_pkg::OP_DECIDE:
                begin
                    idx_reg <= idx_inc[DW-1:0];
                    if (warn_hit)
                    begin
                        if (warns_reg != CNT_MAX)
                            warns_reg <= warns_reg + CNT_ONE;
                        if (warn_total_reg != TOT_MAX)
                            warn_total_reg <= warn_total_reg + TOT_ONE;
                    end
                    else if (edge_ok)
                    begin
                        row_valid_reg[held_reg] <= 1'b1;
                        edge_total_reg          <= edge_total_reg + EW'(1);
                        if (added_reg != CNT_MAX)
                            added_reg <= added_reg + CNT_ONE;
                    end
                end
                locd_pkg::OP_PUSH:
                begin
                    if (stk_room)
                        depth_reg <= depth_reg + DW'(1);
                end
                locd_pkg::OP_REL_RD:
                begin
                    idx_reg <= idx_dec;
                end
                locd_pkg::OP_SH_WR:
                begin
                    idx_reg <= idx_inc[DW-1:0];
                end
                locd_pkg::OP_POP:
                begin
                    depth_reg <= depth_reg - DW'(1);
                end
                locd_pkg::OP_MISS:
                begin
                    missing_reg <= 1'b1;
                end
                locd_pkg::OP_OUT:
                begin
                    out_warns_reg <= warns_reg;
                    out_added_reg <= added_reg;
                    out_held_reg  <= (depth_wide > 7'd31) ? CNT_MAX : depth_wide[4:0];
                    out_miss_reg  <= missing_reg;
                    out_total_reg <= warn_total_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign cycle_warnings = out_warns_reg;
    assign edges_added    = out_added_reg;
    assign held_count     = out_held_reg;
    assign not_held       = out_miss_reg;
    assign warnings_total = out_total_reg;

endmodule

### src/lock_order_cycle_detector.sv
// channel | direction | handshake           | beat
// in      | input     | in_valid / in_stall  | cmd, lock_class
// out     | output    | out_valid / out_stall| cycle_warnings, edges_added, held_count,
//         |           |                      | not_held, warnings_total
//
// one event at a time; a release scans the held stack from the top, then shifts entries down
// an acquire checks each held class for an existing edge, and where there is none it runs
// reachability sweeps over the order matrix (1 to NUM_CLASSES sweeps) before it decides
// reset clears the graph through row valid bits at once, no clearing pass
// a result waits in the output register; the next event is taken meanwhile
module lock_order_cycle_detector #(
    parameter int unsigned NUM_CLASSES = 32,
    parameter int unsigned EDGE_LIMIT  = 256,
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         cmd,
    input  logic [locd_pkg::CLASS_W-1:0] lock_class,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [locd_pkg::COUNT_W-1:0] cycle_warnings,
    output logic [locd_pkg::COUNT_W-1:0] edges_added,
    output logic [locd_pkg::COUNT_W-1:0] held_count,
    output logic                         not_held,
    output logic [locd_pkg::TOTAL_W-1:0] warnings_total
);

    locd_pkg::dp_op_t     op;
    locd_pkg::dp_status_t status;

    // sequencer
    locd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .op       (op)
    );

    // graph, stack and counters
    locd_dp #(
        .NUM_CLASSES (NUM_CLASSES),
        .EDGE_LIMIT  (EDGE_LIMIT),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .status         (status),
        .cmd            (cmd),
        .lock_class     (lock_class),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cycle_warnings (cycle_warnings),
        .edges_added    (edges_added),
        .held_count     (held_count),
        .not_held       (not_held),
        .warnings_total (warnings_total)
    );

endmodule

### sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NCLS   = 32;
    localparam int unsigned ELIMIT = 256;
    localparam int unsigned SDEPTH = 16;
    localparam int unsigned IDLE_LIMIT = 200000;

    localparam bit CMD_ACQUIRE = 1'b0;
    localparam bit CMD_RELEASE = 1'b1;

    typedef struct packed {
        logic                          cmd;
        logic [locd_pkg::CLASS_W-1:0]  cls;
    } lock_event_t;

    typedef struct packed {
        logic [locd_pkg::COUNT_W-1:0]  warns;
        logic [locd_pkg::COUNT_W-1:0]  added;
        logic [locd_pkg::COUNT_W-1:0]  depth;
        logic                          missing;
        logic [locd_pkg::TOTAL_W-1:0]  total;
    } lock_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic cmd = 1'b0;
    logic [locd_pkg::CLASS_W-1:0] lock_class = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [locd_pkg::COUNT_W-1:0] cycle_warnings;
    logic [locd_pkg::COUNT_W-1:0] edges_added;
    logic [locd_pkg::COUNT_W-1:0] held_count;
    logic not_held;
    logic [locd_pkg::TOTAL_W-1:0] warnings_total;

    lock_order_cycle_detector u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .lock_class(lock_class),
        .out_valid(out_valid), .out_stall(out_stall),
        .cycle_warnings(cycle_warnings), .edges_added(edges_added),
        .held_count(held_count), .not_held(not_held),
        .warnings_total(warnings_total)
    );

    always #5 clk = ~clk;

    // predictor state: order graph, held stack, counters
    logic [NCLS-1:0]              graph [NCLS];
    int unsigned                  graph_edges;
    logic [locd_pkg::CLASS_W-1:0] held [SDEPTH];
    int unsigned                  held_depth;
    int unsigned                  warn_sum;

    lock_event_t  pending_events [$];
    lock_report_t expected_reports [$];
    int unsigned  mismatches;
    int unsigned  reports_seen;
    int unsigned  idle_cycles;
    int unsigned  acquires_sent;
    int unsigned  releases_sent;
    int unsigned  warn_reports;
    int unsigned  sat_edges;
    bit           hold_sender;
    bit           long_hold_req;
    bit           stimulus_done;

    function automatic logic [NCLS-1:0] reachable_set(logic [locd_pkg::CLASS_W-1:0] start);
        logic [NCLS-1:0] r;
        logic [NCLS-1:0] nxt;
        r = '0;
        r[start] = 1'b1;
        forever
        begin
            nxt = r;
            for (int c = 0; c < NCLS; c++)
                if (r[c])
                    nxt |= graph[c];
            if (nxt == r)
                break;
            r = nxt;
        end
        return r;
    endfunction

    function automatic logic [locd_pkg::COUNT_W-1:0] clip5(int unsigned v);
        return (v > 31) ? 5'd31 : v[locd_pkg::COUNT_W-1:0];
    endfunction

    // apply one event to the predictor and return its report
    function automatic lock_report_t apply_lock_event(lock_event_t ev);
        lock_report_t rep;
        int unsigned warns;
        int unsigned added;
        bit found;
        logic [locd_pkg::CLASS_W-1:0] h;
        logic [NCLS-1:0] reach_set;
        warns = 0;
        added = 0;
        found = 1'b0;
        if (ev.cmd == CMD_ACQUIRE)
        begin
            for (int i = 0; i < held_depth; i++)
            begin
                h = held[i];
                if (graph[h][ev.cls])
                    continue;
                reach_set = reachable_set(ev.cls);
                if (reach_set[h])
                begin
                    warns++;
                    if (warn_sum < 65535)
                        warn_sum++;
                    continue;
                end
                if (graph_edges < ELIMIT)
                begin
                    graph[h][ev.cls] = 1'b1;
                    graph_edges++;
                    added++;
                end
            end
            if (held_depth < SDEPTH)
            begin
                held[held_depth] = ev.cls;
                held_depth++;
            end
        end
        else
        begin
            for (int i = int'(held_depth) - 1; i >= 0 && !found; i--)
                if (held[i] == ev.cls)
                begin
                    for (int j = i; j + 1 < held_depth; j++)
                        held[j] = held[j + 1];
                    held_depth--;
                    found = 1'b1;
                end
        end
        rep.warns = clip5(warns);
        rep.added = clip5(added);
        rep.depth = clip5(held_depth);
        rep.missing = (ev.cmd == CMD_RELEASE) && !found;
        rep.total = warn_sum[locd_pkg::TOTAL_W-1:0];
        return rep;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // driver: present queued beats at the falling edge
    int unsigned send_gap;
    bit          beat_taken;

    always @(posedge clk)
    begin
        beat_taken <= in_valid && !in_stall && rst_n;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !beat_taken)
                ; // hold the stalled beat
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (hold_sender || pending_events.size() == 0)
                in_valid <= 1'b0;
            else
            begin
                in_valid <= 1'b1;
                cmd <= pending_events[0].cmd;
                lock_class <= pending_events[0].cls;
                expected_reports.push_back(apply_lock_event(pending_events.pop_front()));
                send_gap <= gap_len();
            end
        end
    end

    // receiver stall: random gaps, a few long ones, one long hold-off on request
    int unsigned stall_left;
    always @(negedge clk)
    begin
        if (long_hold_req)
        begin
            stall_left <= 400;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= (stall_left > 1);
        end
        else if ($urandom_range(0, 99) < 2)
        begin
            stall_left <= $urandom_range(10, 40);
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < 25);
    end

    // monitor: compare each report with the oldest expectation
    always @(posedge clk)
    begin
        lock_report_t got;
        lock_report_t want;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
            begin
                got.warns = cycle_warnings;
                got.added = edges_added;
                got.depth = held_count;
                got.missing = not_held;
                got.total = warnings_total;
                reports_seen <= reports_seen + 1;
                if (expected_reports.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected report %p", got);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (want.warns != 0)
                        warn_reports <= warn_reports + 1;
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                            $display("report %0d mismatch: expected %p got %p",
                                     reports_seen, want, got);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("timeout with %0d reports outstanding", expected_reports.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic lock_event_t mk(bit c, int unsigned k);
        lock_event_t e;
        e.cmd = c;
        e.cls = k[locd_pkg::CLASS_W-1:0];
        return e;
    endfunction

    task automatic wait_drained();
        while (pending_events.size() != 0 || expected_reports.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    // mostly nested acquire/release over a small class pool, with random noise
    task automatic queue_random_run(int unsigned n);
        logic [locd_pkg::CLASS_W-1:0] mine [$];
        int unsigned base;
        int unsigned span;
        int unsigned pick;
        int unsigned cls_pick;
        base = $urandom_range(0, 24);
        span = $urandom_range(3, 8);
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                pending_events.push_back(mk(bit'($urandom_range(0, 1)),
                                            $urandom_range(0, 31)));
            else if (pick < 55 && mine.size() < 18)
            begin
                cls_pick = base + $urandom_range(0, span - 1);
                mine.push_back(cls_pick[locd_pkg::CLASS_W-1:0]);
                pending_events.push_back(mk(CMD_ACQUIRE, mine[$]));
            end
            else if (mine.size() > 0)
            begin
                pick = (($urandom_range(0, 3) == 0) ? $urandom_range(0, mine.size() - 1)
                        : mine.size() - 1);
                pending_events.push_back(mk(CMD_RELEASE, mine[pick]));
                mine.delete(pick);
            end
            else
                pending_events.push_back(mk(CMD_RELEASE, $urandom_range(0, 31)));
        end
        while (mine.size() > 0)
            pending_events.push_back(mk(CMD_RELEASE, mine.pop_back()));
    endtask

    initial
    begin
        for (int i = 0; i < NCLS; i++)
            graph[i] = '0;
        for (int i = 0; i < SDEPTH; i++)
            held[i] = '0;
        graph_edges = 0; held_depth = 0; warn_sum = 0;
        mismatches = 0; reports_seen = 0; idle_cycles = 0; send_gap = 0;
        warn_reports = 0; stall_left = 0;
        hold_sender = 0; long_hold_req = 0; stimulus_done = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: release on empty, extremes, self-acquire, simple cycle
        pending_events.push_back(mk(CMD_RELEASE, 0));
        pending_events.push_back(mk(CMD_ACQUIRE, 0));
        pending_events.push_back(mk(CMD_ACQUIRE, 31));
        pending_events.push_back(mk(CMD_ACQUIRE, 31));
        pending_events.push_back(mk(CMD_RELEASE, 31));
        pending_events.push_back(mk(CMD_RELEASE, 31));
        pending_events.push_back(mk(CMD_RELEASE, 0));
        pending_events.push_back(mk(CMD_ACQUIRE, 31));
        pending_events.push_back(mk(CMD_ACQUIRE, 0));
        pending_events.push_back(mk(CMD_RELEASE, 21));
        pending_events.push_back(mk(CMD_RELEASE, 31));
        pending_events.push_back(mk(CMD_RELEASE, 0));
        // stack full: 17 acquires, then unwind
        for (int i = 0; i < 17; i++)
            pending_events.push_back(mk(CMD_ACQUIRE, 10 + (i % 12)));
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        for (int i = 0; i < 16; i++)
            pending_events.push_back(mk(CMD_RELEASE, 10 + (i % 12)));
        long_hold_req = 1;
        @(posedge clk);
        long_hold_req = 0;
        wait_drained();

        // random phases; the sender waits for a full drain between them
        for (int ph = 0; ph < 12; ph++)
        begin
            queue_random_run(100);
            wait_drained();
            hold_sender = 1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            hold_sender = 0;
        end
        wait_drained();
        repeat (100) @(posedge clk);

        $display("%0d reports checked, %0d with cycle warnings, %0d edges in the graph",
                 reports_seen, warn_reports, graph_edges);
        $display("%0d warnings counted in total, %0d mismatches", warn_sum, mismatches);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
